@@ rtl/ped_pkg.sv @@
// Shared request codes, status codes and field widths of the event dispatcher.
package ped_pkg;

    localparam int REQ_W    = 3;
    localparam int ID_W     = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_REGISTER   = 3'd0,
        REQ_UNREGISTER = 3'd1,
        REQ_SET        = 3'd2,
        REQ_CLEAR      = 3'd3,
        REQ_DISPATCH   = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_ALREADY = 2'd1,
        ST_NOT_REG = 2'd2
    } t_status;

endpackage

@@ rtl/priority_event_dispatcher_unit.sv @@
// Fixed-priority event scheduler: one item per cycle while the output is not stalled,
// one result item for each request. An item taken is held in the input register,
// and its result is loaded into the result register when that register can take
// it. Both mask updates and the lowest-pending-id pick are done in the logic
// between the registers, so back-to-back items see each other's effects. The
// input side stalls only when the result register holds an item nobody has taken
// and the input register is also full.
// Request codes: 0 register, 1 unregister, 2 set pending, 3 clear pending,
// 4 dispatch; status 0 success, 1 already registered, 2 not registered.
module priority_event_dispatcher_unit
    import ped_pkg::*;
#(
    parameter int EVENT_COUNT = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,     // auto_clear
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,    // req_type[2:0], event_id[7:3]
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata     // status[1:0], dispatch_valid[2], dispatch_id[7:3]
);

    localparam logic [ID_W+1:0] EC_LIMIT = (ID_W+2)'(EVENT_COUNT);

    logic                   r_auto_clear;
    logic [EVENT_COUNT-1:0] r_reg_mask, n_reg_mask;
    logic [EVENT_COUNT-1:0] r_pend_mask, n_pend_mask;

    logic            r_in_valid;
    logic [REQ_W-1:0] r_req;
    logic [ID_W-1:0] r_id;

    logic            r_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic            r_dvalid, n_dvalid;
    logic [ID_W-1:0] r_did, n_did;

    logic                   advance;
    logic                   in_range;
    logic [EVENT_COUNT-1:0] id_bit;
    logic                   is_reg;
    logic                   pick_found;
    logic [ID_W-1:0]        pick_idx;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;

    assign in_range = {2'b00, r_id} < EC_LIMIT;
    assign id_bit   = in_range ? (EVENT_COUNT'(1) << r_id) : '0;
    assign is_reg   = |(r_reg_mask & id_bit);

    ped_prio_enc #(
        .N (EVENT_COUNT)
    ) u_prio_enc (
        .i_vec   (r_pend_mask),
        .o_found (pick_found),
        .o_idx   (pick_idx)
    );

    always_comb begin
        n_reg_mask  = r_reg_mask;
        n_pend_mask = r_pend_mask;
        n_status    = ST_OK;
        n_dvalid    = 1'b0;
        n_did       = '0;
        unique case (t_req'(r_req))
            REQ_REGISTER: begin
                if (!in_range)   n_status = ST_NOT_REG;
                else if (is_reg) n_status = ST_ALREADY;
                else             n_reg_mask = r_reg_mask | id_bit;
            end
            REQ_UNREGISTER: begin
                if (is_reg) n_reg_mask = r_reg_mask & ~id_bit;
                else        n_status = ST_NOT_REG;
            end
            REQ_SET: begin
                if (is_reg) n_pend_mask = r_pend_mask | id_bit;
                else        n_status = ST_NOT_REG;
            end
            REQ_CLEAR: begin
                if (!in_range) n_status = ST_NOT_REG;
                else           n_pend_mask = r_pend_mask & ~id_bit;
            end
            REQ_DISPATCH: begin
                n_dvalid = pick_found;
                n_did    = pick_idx;
                if (pick_found && r_auto_clear) begin
                    n_pend_mask = r_pend_mask & ~(EVENT_COUNT'(1) << pick_idx);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_clear <= 1'b1;
            r_reg_mask   <= '0;
            r_pend_mask  <= '0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_auto_clear <= i_cfg_wr_data;
            end
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_reg_mask  <= n_reg_mask;
                    r_pend_mask <= n_pend_mask;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_req <= i_s_axis_tdata[REQ_W-1:0];
            r_id  <= i_s_axis_tdata[REQ_W+ID_W-1:REQ_W];
        end
        if (advance && r_in_valid) begin
            r_status <= n_status;
            r_dvalid <= n_dvalid;
            r_did    <= n_did;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_did, r_dvalid, r_status};

endmodule

@@ rtl/ped_prio_enc.sv @@
// Lowest-set-bit priority encoder over the pending mask.
module ped_prio_enc
    import ped_pkg::*;
#(
    parameter int N = 32
) (
    input  logic [N-1:0]    i_vec,
    output logic            o_found,
    output logic [ID_W-1:0] o_idx
);

    // Walking from the top down lets the lowest set bit win.
    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (i_vec[i]) begin
                o_found = 1'b1;
                o_idx   = ID_W'(i);
            end
        end
    end

endmodule

@@ rtl/ped_checker.sv @@
// Port-level checks of the event dispatcher and their binding to the top level.
module ped_checker
    import ped_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // A result that is not taken stays and keeps its contents.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // A successful dispatch always carries success status.
    a_dispatch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[2] |-> o_m_axis_tdata[1:0] == ST_OK)
        else $error("dispatch with non-success status");

    // Without a dispatched event the id field is zero.
    a_no_pick_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[2] |-> o_m_axis_tdata[7:3] == 5'd0)
        else $error("dispatch id set without a pick");

    // Status code three is never produced.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[1:0] != 2'd3)
        else $error("undefined status code");

endmodule

bind priority_event_dispatcher_unit ped_checker u_ped_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

@@ dv/priority_event_dispatcher_unit_tb.sv @@
// Self-checking stream testbench for the fixed-priority event dispatcher, with its own scoreboard.
module priority_event_dispatcher_unit_tb;
    import ped_pkg::*;

    localparam int EVENTS      = 32;
    localparam int ID_TOP      = EVENTS - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP   = 40;
    localparam int PHASE_ITEMS = 245;
    localparam int TAIL_CYCLES = 10;

    localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = REQ_W'(REQ_DISPATCH + 1);
    localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = '1;

    typedef struct packed {
        logic             is_cfg;
        logic             cfg_value;
        logic [REQ_W-1:0] req;
        logic [ID_W-1:0]  id;
    } t_request;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [ID_W-1:0]     pick;
    } t_outcome;

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       cfg_we   = 1'b0;
    logic       cfg_data = 1'b0;
    logic       s_valid  = 1'b0;
    logic [7:0] s_data   = '0;  // req_type[2:0], event_id[7:3]
    logic       m_ready  = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_data;          // status[1:0], dispatch_valid[2], dispatch_id[7:3]

    t_request stimulus[$];
    t_outcome expected_outcomes[$];

    logic [EVENTS-1:0] registered_events = '0;
    logic [EVENTS-1:0] pending_events    = '0;
    logic              auto_clear_copy   = 1'b1;

    int errors     = 0;
    int results    = 0;
    int cycles     = 0;
    int send_gap   = 0;
    bit send_calm  = 1'b0;
    int stall_left = 0;
    bit recv_calm  = 1'b0;

    priority_event_dispatcher_unit #(
        .EVENT_COUNT(EVENTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (cfg_we),
        .i_cfg_wr_data  (cfg_data),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data)
    );

    always #5 i_clk = ~i_clk;

    // Applies one request to the mirrored masks and returns the result it should produce.
    function automatic t_outcome dispatch_outcome(logic [REQ_W-1:0] req, logic [ID_W-1:0] id);
        t_outcome o;
        logic     hit;
        o        = '0;
        o.status = ST_OK;
        hit      = registered_events[id];
        if (req == REQ_DISPATCH) begin
            // Scan downward so the last hit is the lowest pending id.
            for (int i = EVENTS - 1; i >= 0; i--) begin
                if (pending_events[i]) begin
                    o.found = 1'b1;
                    o.pick  = ID_W'(i);
                end
            end
            if (o.found && auto_clear_copy) pending_events[o.pick] = 1'b0;
        end else if (req == REQ_REGISTER) begin
            if (hit) o.status = ST_ALREADY;
            else registered_events[id] = 1'b1;
        end else if (req == REQ_UNREGISTER) begin
            if (hit) registered_events[id] = 1'b0;
            else o.status = ST_NOT_REG;
        end else if (req == REQ_SET) begin
            if (hit) pending_events[id] = 1'b1;
            else o.status = ST_NOT_REG;
        end else if (req == REQ_CLEAR) begin
            pending_events[id] = 1'b0;
        end
        return o;
    endfunction

    function automatic int draw_idle(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (errors < PRINT_CAP)
            $display("result %0d: %s got %0d expected %0d", results, what, got, want);
        errors++;
    endtask

    task automatic add_item(logic [REQ_W-1:0] req, logic [ID_W-1:0] id);
        t_request r;
        r     = '0;
        r.req = req;
        r.id  = id;
        stimulus.push_back(r);
    endtask

    // The sender holds a settings change until every outstanding result has come back.
    task automatic add_config(logic value);
        t_request r;
        r           = '0;
        r.is_cfg    = 1'b1;
        r.cfg_value = value;
        stimulus.push_back(r);
    endtask

    // Mostly register/set/dispatch traffic on a few busy ids, with stray requests mixed in.
    task automatic add_random_phase(int count);
        logic [ID_W-1:0]  busy_ids[6];
        logic [REQ_W-1:0] req;
        logic [ID_W-1:0]  id;
        int               kind;
        int               n;
        foreach (busy_ids[k]) busy_ids[k] = ID_W'($urandom_range(0, ID_TOP));
        n = 0;
        while (n < count) begin
            kind = $urandom_range(0, 99);
            if ($urandom_range(0, 9) < 6) id = busy_ids[$urandom_range(0, 5)];
            else id = ID_W'($urandom_range(0, ID_TOP));
            if (kind < 12) begin
                add_item(REQ_REGISTER, id);
                add_item(REQ_SET, id);
                add_item(REQ_DISPATCH, ID_W'($urandom_range(0, ID_TOP)));
                n += 3;
            end else begin
                if (kind < 28) req = REQ_REGISTER;
                else if (kind < 38) req = REQ_UNREGISTER;
                else if (kind < 60) req = REQ_SET;
                else if (kind < 70) req = REQ_CLEAR;
                else if (kind < 94) req = REQ_DISPATCH;
                else req = REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
                add_item(req, id);
                n++;
            end
        end
    endtask

    // Sender: one item per handshake, random gaps in front of each item.
    always @(posedge i_clk) begin
        t_request nxt;
        logic     nxt_valid;
        logic     nxt_we;
        logic     took;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            cfg_we  <= 1'b0;
        end else begin
            took = s_valid && s_ready;
            if (took)
                expected_outcomes.push_back(
                    dispatch_outcome(s_data[REQ_W-1:0], s_data[REQ_W +: ID_W]));
            nxt_valid = s_valid && !took;
            nxt_we    = 1'b0;
            if (!nxt_valid && stimulus.size() != 0) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (!stimulus[0].is_cfg) begin
                    nxt       = stimulus.pop_front();
                    s_data   <= {nxt.id, nxt.req};
                    nxt_valid = 1'b1;
                    if ($urandom_range(0, 59) == 0) send_calm = !send_calm;
                    send_gap = draw_idle(send_calm);
                end else if (expected_outcomes.size() == 0) begin
                    nxt             = stimulus.pop_front();
                    nxt_we          = 1'b1;
                    cfg_data       <= nxt.cfg_value;
                    auto_clear_copy = nxt.cfg_value;
                end
            end
            s_valid <= nxt_valid;
            cfg_we  <= nxt_we;
        end
    end

    // Receiver: stalls of random length, with stall-free stretches now and then.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 79) == 0) recv_calm = !recv_calm;
            if (!recv_calm && $urandom_range(0, 99) < 25) stall_left = draw_idle(1'b0);
        end
    end

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && m_valid && m_ready) begin
            if (expected_outcomes.size() == 0) begin
                report_mismatch("unexpected item, tdata", int'(m_data), 0);
            end else begin
                want = expected_outcomes.pop_front();
                if (m_data[1:0] != want.status)
                    report_mismatch("status", int'(m_data[1:0]), int'(want.status));
                if (m_data[2] != want.found)
                    report_mismatch("dispatch_valid", int'(m_data[2]), int'(want.found));
                if (m_data[7:3] != want.pick)
                    report_mismatch("dispatch_id", int'(m_data[7:3]), int'(want.pick));
            end
            results++;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[priority_event_dispatcher_unit] ERROR");
            $finish;
        end
    end

    initial begin
        add_config(1'b1);
        // Directed part with auto-clear on.
        add_item(REQ_DISPATCH, '0);
        add_item(REQ_REGISTER, '0);
        add_item(REQ_REGISTER, '0);
        add_item(REQ_REGISTER, ID_W'(ID_TOP));
        add_item(REQ_UNREGISTER, 5'd5);
        add_item(REQ_SET, 5'd5);
        add_item(REQ_SET, ID_W'(ID_TOP));
        add_item(REQ_SET, '0);
        add_item(REQ_CLEAR, 5'd7);
        add_item(REQ_DISPATCH, '0);
        add_item(REQ_DISPATCH, '0);
        add_item(REQ_DISPATCH, '0);
        // A pending bit that outlives its unregistration is still dispatched.
        add_item(REQ_SET, '0);
        add_item(REQ_UNREGISTER, '0);
        add_item(REQ_SET, '0);
        add_item(REQ_DISPATCH, ID_W'(ID_TOP));
        add_item(REQ_REGISTER, ID_W'(ID_TOP));
        add_item(REQ_SPARE_FIRST, ID_W'(ID_TOP));
        add_item(REQ_SPARE_FIRST + 1'b1, '0);
        add_item(REQ_SPARE_LAST, ID_W'(ID_TOP));
        add_item(REQ_SET, ID_W'(ID_TOP));
        add_item(REQ_CLEAR, ID_W'(ID_TOP));
        add_item(REQ_DISPATCH, '0);
        // With auto-clear off, dispatch keeps returning the same id.
        add_config(1'b0);
        add_item(REQ_SET, ID_W'(ID_TOP));
        add_item(REQ_DISPATCH, '0);
        add_item(REQ_DISPATCH, '0);
        add_item(REQ_CLEAR, ID_W'(ID_TOP));
        add_item(REQ_DISPATCH, '0);
        for (int p = 0; p < 5; p++) begin
            add_config(p % 2 == 0);
            add_random_phase(PHASE_ITEMS);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (stimulus.size() != 0 || s_valid || expected_outcomes.size() != 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (errors == 0) begin
            $display("[priority_event_dispatcher_unit] OK");
        end else begin
            $display("[priority_event_dispatcher_unit] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ped_pkg.sv
rtl/ped_prio_enc.sv
rtl/priority_event_dispatcher_unit.sv
rtl/ped_checker.sv
dv/priority_event_dispatcher_unit_tb.sv
